// ----- rtl/core/lru_texture_unit_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// lru_texture_unit_allocator_defines.svh
// Assertion macros shared by the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef LRU_TEXTURE_UNIT_ALLOCATOR_DEFINES_SVH
`define LRU_TEXTURE_UNIT_ALLOCATOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define LTUA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LTUA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ltua_pkg.sv -----
// ----------------------------------------------------------------------------
// ltua_pkg
// Shared constants and types of the LRU texture unit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ltua_pkg;

    localparam int SLOTS_DEFAULT           = 16;
    localparam int TEXTURE_ID_BITS_DEFAULT = 16;

    localparam int TEX_W     = 16;  // texture id field width
    localparam int UNIT_W    = 9;   // unit number field width
    localparam int BASE_W    = 8;   // unit_base register width
    localparam int ACT_W     = 5;   // active_slots register width
    localparam int CFG_W     = 8;   // configuration data width
    localparam int CFG_IDX_W = 4;   // configuration index width

    localparam logic [BASE_W-1:0] UNIT_BASE_RESET    = 8'd10;
    localparam logic [ACT_W-1:0]  ACTIVE_SLOTS_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNIT_BASE    = 4'd0,
        REG_ACTIVE_SLOTS = 4'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_texture_unit_allocator.sv -----
// ----------------------------------------------------------------------------
// lru_texture_unit_allocator
// Fully associative texture unit allocator with least recently used
// replacement.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one bind request beat (a texture id). The m_ channel
//   returns one result beat per request: the unit number (unit_base plus the
//   slot index), a hit flag, and the displaced texture id on a miss that
//   evicts a bound slot.
//   A request is captured in an input register; the tag compare, victim pick
//   and recency update then run combinationally into the result register.
//   One request per cycle is sustained while the receiver accepts results;
//   the rate is set by the combinational compare and rank update over all
//   slots.
//   A stalled receiver holds the result register; one more request can sit in
//   the input register, after which s_ready drops.
//   Reset clears all slot valid bits, sets slot i to rank i, unit_base to 10
//   and active_slots to 16. The cfg port writes a register at index 0 or 1
//   whenever cfg_we is high; it is to be used only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_texture_unit_allocator #(
    parameter int SLOTS           = ltua_pkg::SLOTS_DEFAULT,
    parameter int TEXTURE_ID_BITS = ltua_pkg::TEXTURE_ID_BITS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ltua_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ltua_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ltua_pkg::TEX_W-1:0]     s_texture_id,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ltua_pkg::UNIT_W-1:0]         m_unit_number,
    output logic                                m_hit,
    output logic                                m_evicted_valid,
    output logic [ltua_pkg::TEX_W-1:0]          m_evicted_texture
);

    import ltua_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TID_W  = (TEXTURE_ID_BITS < TEX_W) ? TEXTURE_ID_BITS : TEX_W;
    localparam logic [SLOT_W-1:0] TOP_RANK = SLOT_W'(SLOTS - 1);

    // Configuration registers.
    logic [BASE_W-1:0] unit_base_reg;
    logic [ACT_W-1:0]  active_slots_reg;

    // Slot state.
    logic [TID_W-1:0]  slot_tex_reg   [SLOTS];
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOT_W-1:0] rank_reg       [SLOTS];
    logic [SLOT_W-1:0] rank_next      [SLOTS];

    // Input register.
    logic             req_valid_reg;
    logic [TID_W-1:0] req_id_reg;

    // Result register.
    logic              m_valid_reg;
    logic [UNIT_W-1:0] m_unit_number_reg;
    logic              m_hit_reg;
    logic              m_evicted_valid_reg;
    logic [TEX_W-1:0]  m_evicted_texture_reg;

    // Lookup logic.
    logic              advance;
    logic [SLOTS-1:0]  active;
    logic [SLOTS-1:0]  match;
    logic [SLOTS-1:0]  active_by_rank;
    logic [SLOTS-1:0]  victim_oh;
    logic [SLOTS-1:0]  sel_oh;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] hit_rank;
    logic [SLOT_W-1:0] min_rank;
    logic [SLOT_W-1:0] victim_idx;
    logic [TID_W-1:0]  victim_tex;
    logic              victim_valid;
    logic [SLOT_W-1:0] sel_idx;
    logic [SLOT_W-1:0] sel_rank;
    logic              evict;

    assign advance = req_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            // Slot 0 always takes part, so an active count of zero acts as one.
            active[i] = (i == 0) || (32'(active_slots_reg) > 32'(i));
            match[i]  = active[i] && slot_valid_reg[i] && (slot_tex_reg[i] == req_id_reg);
        end
    end

    // Lowest matching slot wins if stale duplicates sit in newly activated slots.
    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx  = SLOT_W'(i);
                hit_rank = rank_reg[i];
            end
        end
    end

    assign hit = |match;

    // Ranks form a permutation, so the lowest rank held by an active slot
    // names exactly one victim.
    always_comb begin
        for (int r = 0; r < SLOTS; r++) begin
            active_by_rank[r] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (active[i] && (rank_reg[i] == SLOT_W'(r))) begin
                    active_by_rank[r] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        min_rank = '0;
        for (int r = SLOTS - 1; r >= 0; r--) begin
            if (active_by_rank[r]) begin
                min_rank = SLOT_W'(r);
            end
        end
    end

    always_comb begin
        victim_idx   = '0;
        victim_tex   = '0;
        victim_valid = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            victim_oh[i] = active[i] && (rank_reg[i] == min_rank);
            if (victim_oh[i]) begin
                victim_idx   = victim_idx | SLOT_W'(i);
                victim_tex   = victim_tex | slot_tex_reg[i];
                victim_valid = victim_valid | slot_valid_reg[i];
            end
        end
    end

    assign sel_idx  = hit ? hit_idx : victim_idx;
    assign sel_rank = hit ? hit_rank : min_rank;
    assign evict    = !hit && victim_valid;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sel_oh[i] = (sel_idx == SLOT_W'(i));
            if (sel_oh[i]) begin
                rank_next[i] = TOP_RANK;
            end else if (rank_reg[i] > sel_rank) begin
                rank_next[i] = rank_reg[i] - SLOT_W'(1);
            end else begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_base_reg    <= UNIT_BASE_RESET;
            active_slots_reg <= ACTIVE_SLOTS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_UNIT_BASE:    unit_base_reg    <= cfg_wdata[BASE_W-1:0];
                REG_ACTIVE_SLOTS: active_slots_reg <= cfg_wdata[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                rank_reg[i] <= SLOT_W'(i);
            end
        end else if (advance) begin
            for (int i = 0; i < SLOTS; i++) begin
                rank_reg[i] <= rank_next[i];
            end
            if (!hit) begin
                slot_valid_reg <= slot_valid_reg | victim_oh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !hit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (victim_oh[i]) begin
                    slot_tex_reg[i] <= req_id_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_id_reg <= TID_W'(s_texture_id);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_unit_number_reg     <= UNIT_W'(unit_base_reg) + UNIT_W'(sel_idx);
            m_hit_reg             <= hit;
            m_evicted_valid_reg   <= evict;
            m_evicted_texture_reg <= evict ? TEX_W'(victim_tex) : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_unit_number     = m_unit_number_reg;
    assign m_hit             = m_hit_reg;
    assign m_evicted_valid   = m_evicted_valid_reg;
    assign m_evicted_texture = m_evicted_texture_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ltua_checker.sv -----
// ----------------------------------------------------------------------------
// ltua_checker
// Port-level checks of the LRU texture unit allocator, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_texture_unit_allocator_defines.svh"

module ltua_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [ltua_pkg::UNIT_W-1:0]  m_unit_number,
    input wire logic                         m_hit,
    input wire logic                         m_evicted_valid,
    input wire logic [ltua_pkg::TEX_W-1:0]   m_evicted_texture
);

    import ltua_pkg::*;

    // A hit never displaces a texture.
    `LTUA_ASSERT(a_hit_no_evict, aclk, aresetn, m_valid && m_hit |-> !m_evicted_valid, "hit beat reports an eviction")

    // Without an eviction the displaced id reads as zero.
    `LTUA_ASSERT(a_evict_zero, aclk, aresetn, m_valid && !m_evicted_valid |-> m_evicted_texture == '0, "evicted texture nonzero without eviction")

    // No result beat is offered in the cycle after reset.
    `LTUA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    // A stalled result beat stays valid and holds its unit number and hit flag.
    `LTUA_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_unit_number) && $stable(m_hit), "stalled result beat changed")

endmodule

bind lru_texture_unit_allocator ltua_checker u_ltua_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU texture unit allocator.
// A directed table covers the register extremes, hits, evictions and
// inactive slots, then random phases reconfigure the block and send bind
// requests drawn mostly from a small working set of texture ids. Every result
// beat is compared with a hand-worked result or a software allocator in the bench.
// ----------------------------------------------------------------------------
module tb;
    import ltua_pkg::*;

    localparam int SLOTS  = SLOTS_DEFAULT;
    localparam int RANK_W = $clog2(SLOTS);
    localparam int PHASES = 12;
    localparam int BINDS_PER_PHASE = 150;
    localparam int POOL_MAX = 40;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_number;
        logic              hit;
        logic              evicted_valid;
        logic [TEX_W-1:0]  evicted_texture;
    } bind_result_t;

    typedef enum logic {ROW_BIND, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     wdata;
        logic [TEX_W-1:0]     texture_id;
        logic                 fixed;
        bind_result_t         expected;
    } row_t;

    localparam int DIRECTED_ROWS = 25;

    // Rows with fixed set carry a hand-worked result; the rest use the predictor.
    row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BIND,  '0, '0, 16'h0000, 1'b1, '{9'd10,  1'b0, 1'b0, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'hFFFF, 1'b1, '{9'd11,  1'b0, 1'b0, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'h0000, 1'b1, '{9'd10,  1'b1, 1'b0, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'hA5A5, 1'b1, '{9'd12,  1'b0, 1'b0, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'hFFFF, 1'b1, '{9'd11,  1'b1, 1'b0, 16'h0000}},
        '{ROW_WRITE, REG_ACTIVE_SLOTS, 8'h01, '0, 1'b0, '0},
        '{ROW_WRITE, REG_UNIT_BASE,    8'hFF, '0, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'h1234, 1'b1, '{9'd255, 1'b0, 1'b1, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'hFFFF, 1'b1, '{9'd255, 1'b0, 1'b1, 16'h1234}},
        '{ROW_WRITE, REG_ACTIVE_SLOTS, 8'h00, '0, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'hFFFF, 1'b1, '{9'd255, 1'b1, 1'b0, 16'h0000}},
        '{ROW_WRITE, REG_ACTIVE_SLOTS, 8'hFF, '0, 1'b0, '0},
        '{ROW_WRITE, REG_UNIT_BASE,    8'h00, '0, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'hA5A5, 1'b1, '{9'd2,   1'b1, 1'b0, 16'h0000}},
        '{ROW_WRITE, REG_LAST_INDEX,   8'h55, '0, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'hA5A5, 1'b1, '{9'd2,   1'b1, 1'b0, 16'h0000}},
        '{ROW_BIND,  '0, '0, 16'h5A5A, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'h8000, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'h7FFF, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'h0001, 1'b0, '0},
        '{ROW_WRITE, REG_UNIT_BASE,    8'h80, '0, 1'b0, '0},
        '{ROW_WRITE, REG_ACTIVE_SLOTS, 8'h10, '0, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'hFFFF, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'h0000, 1'b0, '0},
        '{ROW_BIND,  '0, '0, 16'hFFFE, 1'b0, '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TEX_W-1:0]     s_texture_id = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [UNIT_W-1:0]    m_unit_number;
    logic                 m_hit;
    logic                 m_evicted_valid;
    logic [TEX_W-1:0]     m_evicted_texture;

    lru_texture_unit_allocator i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_texture_id      (s_texture_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_number     (m_unit_number),
        .m_hit             (m_hit),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_texture (m_evicted_texture)
    );

    // Shadow copy of the allocator state and registers.
    logic [TEX_W-1:0]  bound_texture [SLOTS];
    logic              bound_valid   [SLOTS];
    logic [RANK_W-1:0] lru_rank      [SLOTS];
    logic [BASE_W-1:0] unit_base_reg = UNIT_BASE_RESET;
    logic [ACT_W-1:0]  active_slots_reg = ACTIVE_SLOTS_RESET;

    bind_result_t expected_binds [$];
    bind_result_t oldest_bind;
    int           errors = 0;
    bit           tx_greedy = 1'b0;
    bit           rx_greedy = 1'b0;
    int           ready_hold = 0;
    int           ready_pick;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("[lru_texture_unit_allocator] ERROR");
        $finish;
    end

    // Computes the outcome of one bind request and updates the shadow state.
    function automatic bind_result_t allocate_unit(input logic [TEX_W-1:0] id);
        bind_result_t      res;
        int                active;
        int                slot;
        int                best;
        logic              found;
        logic [RANK_W-1:0] old_rank;

        res = '0;
        active = (active_slots_reg == 0) ? 1 :
                 (active_slots_reg > SLOTS) ? SLOTS : int'(active_slots_reg);
        slot = 0;
        found = 1'b0;
        for (int i = 0; i < active; i++) begin
            if (!found && bound_valid[i] && bound_texture[i] == id) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            best = SLOTS;
            for (int i = 0; i < active; i++) begin
                if (int'(lru_rank[i]) < best) begin
                    best = int'(lru_rank[i]);
                    slot = i;
                end
            end
            if (bound_valid[slot]) begin
                res.evicted_valid = 1'b1;
                res.evicted_texture = bound_texture[slot];
            end
            bound_texture[slot] = id;
            bound_valid[slot] = 1'b1;
        end
        old_rank = lru_rank[slot];
        for (int i = 0; i < SLOTS; i++) begin
            if (lru_rank[i] > old_rank) lru_rank[i] = lru_rank[i] - 1'b1;
        end
        lru_rank[slot] = RANK_W'(SLOTS - 1);
        res.unit_number = UNIT_W'(unit_base_reg) + UNIT_W'(slot);
        res.hit = found;
        return res;
    endfunction

    // Presents one request beat; returns at the edge where it is accepted.
    task automatic send_bind(input logic [TEX_W-1:0] id, input logic fixed,
                             input bind_result_t fixed_result);
        bind_result_t predicted;
        int           gap;
        int           pick;

        predicted = allocate_unit(id);
        expected_binds.insert(expected_binds.size(), fixed ? fixed_result : predicted);
        pick = $urandom_range(0, 99);
        if (tx_greedy || pick < 55) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_texture_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Register writes only happen once every outstanding result has drained.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] wdata);
        s_valid <= 1'b0;
        while (expected_binds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= wdata;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == REG_UNIT_BASE) unit_base_reg = wdata;
        else if (index == REG_ACTIVE_SLOTS) active_slots_reg = wdata[ACT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [TEX_W-1:0] expected,
                               input logic [TEX_W-1:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
            errors++;
        end
    endtask

    // Result side: random stalls, mostly short, some long, some phases none.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else if (rx_greedy) begin
            m_ready <= 1'b1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                ready_hold = (ready_pick < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_binds.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got unit %0d",
                         $time, m_unit_number);
                errors++;
            end else begin
                oldest_bind = expected_binds[0];
                expected_binds.delete(0);
                check_field("unit_number", TEX_W'(oldest_bind.unit_number),
                            TEX_W'(m_unit_number));
                check_field("hit", TEX_W'(oldest_bind.hit), TEX_W'(m_hit));
                check_field("evicted_valid", TEX_W'(oldest_bind.evicted_valid),
                            TEX_W'(m_evicted_valid));
                check_field("evicted_texture", oldest_bind.evicted_texture,
                            m_evicted_texture);
            end
        end
    end

    initial begin
        logic [TEX_W-1:0] id_pool [POOL_MAX];
        logic [TEX_W-1:0] id;
        int               pool_size;
        int               choice;

        for (int i = 0; i < SLOTS; i++) begin
            bound_texture[i] = '0;
            bound_valid[i] = 1'b0;
            lru_rank[i] = RANK_W'(i);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_register(directed_rows[r].reg_index, directed_rows[r].wdata);
            end else begin
                send_bind(directed_rows[r].texture_id, directed_rows[r].fixed,
                          directed_rows[r].expected);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            choice = $urandom_range(0, 3);
            if (choice != 3) begin
                case ($urandom_range(0, 3))
                    0: write_register(REG_UNIT_BASE, 8'h00);
                    1: write_register(REG_UNIT_BASE, 8'hFF);
                    default: write_register(REG_UNIT_BASE, CFG_W'($urandom));
                endcase
            end
            if (choice != 2) begin
                case ($urandom_range(0, 5))
                    0: write_register(REG_ACTIVE_SLOTS, {3'($urandom), 5'd0});
                    1: write_register(REG_ACTIVE_SLOTS, {3'($urandom), 5'd1});
                    2: write_register(REG_ACTIVE_SLOTS, {3'($urandom), 5'd16});
                    3: write_register(REG_ACTIVE_SLOTS,
                                      {3'($urandom), 5'($urandom_range(17, 31))});
                    default: write_register(REG_ACTIVE_SLOTS,
                                            {3'($urandom), 5'($urandom_range(2, 15))});
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                write_register(CFG_IDX_W'($urandom_range(int'(REG_ACTIVE_SLOTS) + 1,
                                                          int'(REG_LAST_INDEX))),
                               CFG_W'($urandom));
            end

            tx_greedy = ($urandom_range(0, 3) == 0);
            rx_greedy = ($urandom_range(0, 3) == 0);
            pool_size = $urandom_range(2, POOL_MAX);
            for (int i = 0; i < POOL_MAX; i++) id_pool[i] = TEX_W'($urandom);

            // Mostly a small working set so that hits and LRU order matter.
            for (int k = 0; k < BINDS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < 75) begin
                    id = id_pool[$urandom_range(0, pool_size - 1)];
                end else begin
                    id = TEX_W'($urandom);
                    if ($urandom_range(0, 1) == 1) id_pool[$urandom_range(0, pool_size - 1)] = id;
                end
                send_bind(id, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        tx_greedy = 1'b0;
        while (expected_binds.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("[lru_texture_unit_allocator] OK");
        end else begin
            $display("[lru_texture_unit_allocator] ERROR");
        end
        $finish;
    end

endmodule
